FILE: hdl/ctc_pkg.sv
package ctc_pkg;

  localparam int MAX_CLASSES = 16384;
  localparam int MAX_STEPS   = 1024;

  localparam int PROB_W  = 17;
  localparam int LABEL_W = 14;
  localparam int CHAR_W  = 15;
  localparam int SUM_W   = 27;
  localparam int CLASS_W = $clog2(MAX_CLASSES);
  localparam int COUNT_W = $clog2(MAX_STEPS + 1);
  localparam int STEP_W  = $clog2(SUM_W);

  localparam int PROB_ONE   = 65536;
  localparam int CHAR_RESET = 16384;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_LABEL = 1'b0;
  localparam logic KIND_MEAN  = 1'b1;

  typedef struct packed {
    logic [PROB_W-1:0] class_prob;
    logic              step_end;
    logic              sequence_end;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic [LABEL_W-1:0] label_index;
    logic               has_character;
    logic [PROB_W-1:0]  mean_confidence;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic               has_label;
    logic [LABEL_W-1:0] label;
    logic               has_char;
    logic               seq_end;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } q_entry_t;

endpackage

FILE: hdl/ctc_queue.sv
module ctc_queue
  import ctc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  logic     pop,
  input  q_entry_t wr_data,
  output q_entry_t rd_data,
  output logic     full,
  output logic     empty
);

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head;
  logic [QPTR_W-1:0]   tail;
  logic [QCNT_W-1:0]   count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == QCNT_W'($past(count) + 1'b1))
    else $error("queue count did not advance");
`endif

endmodule

FILE: hdl/ctc_div.sv
module ctc_div
  import ctc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   sum,
  input  logic [COUNT_W-1:0] count,
  output logic               done,
  output logic [PROB_W-1:0]  mean
);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [SUM_W-1:0]   num;
  logic [COUNT_W-1:0] den;
  logic [COUNT_W-1:0] rem;
  logic [SUM_W-1:0]   quo;
  logic [COUNT_W:0]   trial;
  logic               ge;

  assign trial = {rem, num[SUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_comb begin
    if (den == '0) begin
      mean = '0;
    end else if (quo > SUM_W'(PROB_ONE)) begin
      mean = PROB_W'(PROB_ONE);
    end else begin
      mean = quo[PROB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W - 1);
        num  <= sum + SUM_W'(count >> 1);
        den  <= count;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        rem  <= ge ? COUNT_W'(trial - {1'b0, den}) : trial[COUNT_W-1:0];
        num  <= num << 1;
        quo  <= {quo[SUM_W-2:0], ge};
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/ctc_front.sv
module ctc_front
  import ctc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CHAR_W-1:0] cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output q_entry_t          q_data
);

  logic [CHAR_W-1:0]  char_count;
  logic [PROB_W-1:0]  best_prob;
  logic [CLASS_W-1:0] best_class;
  logic [CLASS_W-1:0] class_pos;
  logic [LABEL_W-1:0] prev_label;
  logic               prev_valid;
  logic [SUM_W-1:0]   sum;
  logic [COUNT_W-1:0] kept;

  logic               accept;
  logic [PROB_W-1:0]  prob_sat;
  logic               take;
  logic [PROB_W-1:0]  cur_prob;
  logic [CLASS_W-1:0] cur_class;
  logic [LABEL_W-1:0] label;
  logic               keep;
  logic               add;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] kept_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  assign prob_sat  = (in_data.class_prob > PROB_W'(PROB_ONE)) ? PROB_W'(PROB_ONE)
                                                               : in_data.class_prob;
  assign take      = (class_pos == '0) || (prob_sat > best_prob);
  assign cur_prob  = take ? prob_sat : best_prob;
  assign cur_class = take ? class_pos : best_class;
  assign label     = LABEL_W'(cur_class);
  assign keep      = (label != '0) && !(prev_valid && (label == prev_label));
  assign add       = keep && (kept < COUNT_W'(MAX_STEPS));
  assign sum_next  = add ? sum + SUM_W'(cur_prob) : sum;
  assign kept_next = add ? kept + 1'b1 : kept;

  assign q_push = accept && in_data.step_end && (keep || in_data.sequence_end);

  always_comb begin
    q_data.has_label = keep;
    q_data.label     = label;
    q_data.has_char  = {1'b0, label} < char_count;
    q_data.seq_end   = in_data.sequence_end;
    q_data.sum       = sum_next;
    q_data.count     = kept_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= CHAR_W'(CHAR_RESET);
    end else if (cfg_valid && cfg_ready) begin
      char_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_prob  <= '0;
      best_class <= '0;
      class_pos  <= '0;
      prev_label <= '0;
      prev_valid <= 1'b0;
      sum        <= '0;
      kept       <= '0;
    end else if (accept) begin
      if (!in_data.step_end) begin
        best_prob  <= cur_prob;
        best_class <= cur_class;
        if (class_pos < CLASS_W'(MAX_CLASSES - 1)) begin
          class_pos <= class_pos + 1'b1;
        end
      end else begin
        best_prob  <= '0;
        best_class <= '0;
        class_pos  <= '0;
        if (in_data.sequence_end) begin
          prev_label <= '0;
          prev_valid <= 1'b0;
          sum        <= '0;
          kept       <= '0;
        end else begin
          prev_label <= label;
          prev_valid <= 1'b1;
          sum        <= sum_next;
          kept       <= kept_next;
        end
      end
    end
  end

endmodule

FILE: hdl/ctc_back.sv
module ctc_back
  import ctc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  q_entry_t q_data,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LABEL = 4'b0010,
    S_DIV   = 4'b0100,
    S_MEAN  = 4'b1000
  } state_t;

  state_t             state;
  q_entry_t           cur;
  logic               accepted;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_sum;
  logic [COUNT_W-1:0] div_count;
  logic [PROB_W-1:0]  div_mean;

  assign accepted = out_valid && !out_stall;

  assign q_pop = !q_empty && ((state == S_IDLE)
                              || ((state == S_LABEL) && accepted && !cur.seq_end)
                              || ((state == S_MEAN) && accepted));

  assign div_start = (q_pop && !q_data.has_label)
                     || ((state == S_LABEL) && accepted && cur.seq_end);
  assign div_sum   = q_pop ? q_data.sum : cur.sum;
  assign div_count = q_pop ? q_data.count : cur.count;

  ctc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (div_sum),
    .count (div_count),
    .done  (div_done),
    .mean  (div_mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else if (q_pop) begin
      cur <= q_data;
      if (q_data.has_label) begin
        out_valid                <= 1'b1;
        out_data.result_kind     <= KIND_LABEL;
        out_data.label_index     <= q_data.label;
        out_data.has_character   <= q_data.has_char;
        out_data.mean_confidence <= '0;
        out_data.last_result     <= 1'b0;
        state                    <= S_LABEL;
      end else begin
        out_valid <= 1'b0;
        state     <= S_DIV;
      end
    end else begin
      case (state)
        S_IDLE: begin
          out_valid <= 1'b0;
        end
        S_LABEL: begin
          if (accepted) begin
            out_valid <= 1'b0;
            state     <= cur.seq_end ? S_DIV : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_valid                <= 1'b1;
            out_data.result_kind     <= KIND_MEAN;
            out_data.label_index     <= '0;
            out_data.has_character   <= 1'b0;
            out_data.mean_confidence <= div_mean;
            out_data.last_result     <= 1'b1;
            state                    <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (accepted) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/ctc_greedy_decoder.sv
// CTC greedy best-path decoder.
// Input channel: in_valid / in_stall / in_data, one class probability per
// word, classes of a timestep in order; step_end closes a timestep and
// sequence_end (seen only with step_end) closes the sequence.
// Output channel: out_valid / out_stall / out_data. Each kept label gives a
// label word; each sequence end gives a mean-confidence word with
// last_result set.
// Configuration: cfg_valid / cfg_ready / cfg_data writes character_count;
// cfg_ready is always high. Write only while the block is idle.
// Throughput: one input word per cycle while the four-entry queue between
// the front and back halves has room. A label word leaves at most once per
// cycle; a label word passes through the queue and then the output register.
// The mean word is computed after the closing word by the bit-serial
// divider, one quotient bit per cycle.
// Reset (synchronous, rst high) empties the queue, clears all decoding
// state and sets character_count to 16384; no sweep follows.
// A stalled output word holds; the queue fills and in_stall rises once
// four entries wait.
module ctc_greedy_decoder
  import ctc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CHAR_W-1:0] cfg_data
);

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t q_wr;
  q_entry_t q_rd;

  ctc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr)
  );

  ctc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .pop     (q_pop),
    .wr_data (q_wr),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  ctc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_rd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
